### rtl/tile_halfspace_coverage_core_assert.svh
// Assertion macros shared by the tile coverage RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef TILE_HALFSPACE_COVERAGE_CORE_ASSERT_SVH
`define TILE_HALFSPACE_COVERAGE_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define THC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// An implication checked in the same cycle.
`define THC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`THC_ASSERT(lbl, ((ante) |-> (cons)), msg)

`endif

### rtl/thc_pkg.sv
// Shared constants, codes and stage payload types of the tile coverage block.
// Has no dependencies; every RTL module imports it.
package thc_pkg;

	localparam int BLOCK_SIZE    = 8;
	localparam int BLOCK_SHIFT   = $clog2(BLOCK_SIZE);
	localparam int MASK_STRIDE   = 8;
	localparam int MASK_W        = 64;
	localparam int SUBPIXEL_BITS = 4;
	localparam int SUB_MASK      = (1 << SUBPIXEL_BITS) - 1;

	localparam int COORD_W   = 16;
	localparam int COL_W     = 8;
	localparam int SCR_W     = 12;
	localparam int CFG_IDX_W = 2;

	// Rounded pixel coordinates and their differences.
	localparam int PIX_W   = COORD_W + 1 - SUBPIXEL_BITS;
	localparam int BOX_W   = PIX_W + 1;
	localparam int PDIFF_W = PIX_W + 1;
	localparam int AREA_W  = 2 * PDIFF_W;

	// Edge arithmetic in subpixel units.
	localparam int DIFF_W = COORD_W + 1;
	localparam int BPOS_W = COL_W + BLOCK_SHIFT;
	localparam int SAMP_W = BPOS_W + SUBPIXEL_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int EDGE_W = PROD_W + 2;
	localparam int STEP_W = DIFF_W + BLOCK_SHIFT + 1;

	localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = SCR_W'(640);
	localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = SCR_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CLASS_REJECT  = 2'd0,
		CLASS_PARTIAL = 2'd1,
		CLASS_FULL    = 2'd2
	} corner_class_t;

	typedef enum logic [1:0] {
		TRI_DRAWN      = 2'd0,
		TRI_ZERO_AREA  = 2'd1,
		TRI_OFF_SCREEN = 2'd2
	} tri_status_t;

	// Products and bounds handed from the front end to the edge stage.
	typedef struct packed {
		logic [AREA_W-1:0]              area_a;
		logic [AREA_W-1:0]              area_b;
		logic [2:0][PROD_W-1:0]         cy;
		logic [2:0][PROD_W-1:0]         cx;
		logic [2:0][PROD_W-1:0]         qy;
		logic [2:0][PROD_W-1:0]         qx;
		logic [PIX_W-1:0]               min_x;
		logic [PIX_W-1:0]               max_x;
		logic [PIX_W-1:0]               min_y;
		logic [PIX_W-1:0]               max_y;
		logic [2:0][DIFF_W-1:0]         dx;
		logic [2:0][DIFF_W-1:0]         dy;
		logic [2:0]                     bias;
		logic [BPOS_W-1:0]              bx;
		logic [BPOS_W-1:0]              by;
	} s2_t;

	// Edge values at the block origin plus per-row and per-column steps.
	typedef struct packed {
		tri_status_t                            status;
		logic                                   visited;
		logic [2:0][EDGE_W-1:0]                 c_part;
		logic [2:0][EDGE_W-1:0]                 s_part;
		logic [2:0][BLOCK_SIZE-1:0][STEP_W-1:0] rstep;
		logic [2:0][BLOCK_SIZE-1:0][STEP_W-1:0] cstep;
	} s3_t;

	typedef struct packed {
		logic [MASK_W-1:0] coverage_mask;
		corner_class_t     corner_class;
		logic              visited;
		tri_status_t       status;
	} res_t;

	// Mask with every pixel of the block set.
	function automatic logic [MASK_W-1:0] full_mask();
		logic [MASK_W-1:0] m;
		m = '0;
		for (int r = 0; r < BLOCK_SIZE; r++) begin
			for (int k = 0; k < BLOCK_SIZE; k++) begin
				m[r*MASK_STRIDE+k] = 1'b1;
			end
		end
		return m;
	endfunction

endpackage

### rtl/tile_halfspace_coverage_core.sv
// Top level of the tile coverage block: configuration registers, stall control, ports.
// Depends on thc_pkg, thc_front, thc_edge, thc_pixel and the assertion macro header.
//
// Usage: each input transaction carries three triangle vertices in signed 12.4 fixed
// point and the column and row of one 8x8 pixel block. One output transaction follows
// for each input: the block's 64-bit coverage mask, its corner class, whether the
// clamped traversal box reaches it, and the triangle status.
// Throughput is one transaction per clock while out_ready does not hold the pipeline.
// The datapath is five register stages (rounding and deltas, multipliers, edge constants
// and box test, row values, pixel tests), and a result passes through all five before
// it appears on out_valid.
// When out_ready is low with a result waiting, the whole pipeline holds and in_ready
// drops in the same cycle; nothing is dropped or repeated.
// The configuration channel is always ready and writes screen_width (index 0) or
// screen_height (index 1); other indexes are ignored. Write it only while idle.
// Reset clears all stage valid bits and sets the screen to 640 by 480.
`include "tile_halfspace_coverage_core_assert.svh"

module tile_halfspace_coverage_core import thc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] vertex_a_x,
	input  logic signed [COORD_W-1:0] vertex_a_y,
	input  logic signed [COORD_W-1:0] vertex_b_x,
	input  logic signed [COORD_W-1:0] vertex_b_y,
	input  logic signed [COORD_W-1:0] vertex_c_x,
	input  logic signed [COORD_W-1:0] vertex_c_y,
	input  logic [COL_W-1:0]          block_col,
	input  logic [COL_W-1:0]          block_row,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [MASK_W-1:0]         coverage_mask,
	output logic [1:0]                corner_class,
	output logic                      block_visited,
	output logic [1:0]                triangle_status,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [SCR_W-1:0]          cfg_data
);

	logic [SCR_W-1:0] screen_width_q;
	logic [SCR_W-1:0] screen_height_q;
	logic             en;
	logic             valid_s2, valid_s3, valid_s5;
	s2_t              data_s2;
	s3_t              data_s3;
	res_t             res_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: begin
					screen_width_q <= cfg_data;
				end
				REG_SCREEN_HEIGHT: begin
					screen_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// All stages advance together unless a finished result is waiting on the receiver.
	assign en       = !valid_s5 || out_ready;
	assign in_ready = en;

	thc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.vertex_a_x (vertex_a_x),
		.vertex_a_y (vertex_a_y),
		.vertex_b_x (vertex_b_x),
		.vertex_b_y (vertex_b_y),
		.vertex_c_x (vertex_c_x),
		.vertex_c_y (vertex_c_y),
		.block_col  (block_col),
		.block_row  (block_row),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	thc_edge u_edge (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.valid_s2      (valid_s2),
		.data_s2       (data_s2),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.valid_s3      (valid_s3),
		.data_s3       (data_s3)
	);

	thc_pixel u_pixel (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s5 (valid_s5),
		.res_s5   (res_s5)
	);

	assign out_valid       = valid_s5;
	assign coverage_mask   = res_s5.coverage_mask;
	assign corner_class    = res_s5.corner_class;
	assign block_visited   = res_s5.visited;
	assign triangle_status = res_s5.status;

	`THC_ASSERT_IMPLY(a_undrawn_empty, out_valid && res_s5.status != TRI_DRAWN, coverage_mask == '0 && res_s5.corner_class == CLASS_REJECT && !block_visited, "undrawn triangle reports coverage")
	`THC_ASSERT_IMPLY(a_reject_empty, out_valid && res_s5.corner_class == CLASS_REJECT, coverage_mask == '0, "rejected block has pixels set")
	`THC_ASSERT_IMPLY(a_full_mask, out_valid && res_s5.corner_class == CLASS_FULL, coverage_mask == full_mask(), "fully covered block has pixels clear")

endmodule

### rtl/thc_front.sv
// Front end of the tile coverage pipeline: vertex rounding, edge deltas and all products.
// Depends on thc_pkg.
module thc_front import thc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] vertex_a_x,
	input  logic signed [COORD_W-1:0] vertex_a_y,
	input  logic signed [COORD_W-1:0] vertex_b_x,
	input  logic signed [COORD_W-1:0] vertex_b_y,
	input  logic signed [COORD_W-1:0] vertex_c_x,
	input  logic signed [COORD_W-1:0] vertex_c_y,
	input  logic [COL_W-1:0]          block_col,
	input  logic [COL_W-1:0]          block_row,
	output logic                      valid_s2,
	output s2_t                       data_s2
);

	typedef struct packed {
		logic [2:0][PIX_W-1:0]   ix;
		logic [2:0][PIX_W-1:0]   iy;
		logic [2:0][COORD_W-1:0] vx;
		logic [2:0][COORD_W-1:0] vy;
		logic [2:0][DIFF_W-1:0]  dx;
		logic [2:0][DIFF_W-1:0]  dy;
		logic [2:0]              bias;
		logic [BPOS_W-1:0]       bx;
		logic [BPOS_W-1:0]       by;
	} s1_t;

	// Round a 12.4 coordinate up to whole pixels.
	function automatic logic [PIX_W-1:0] ceil_pix(input logic [COORD_W-1:0] v);
		logic [COORD_W:0] t;
		t = {v[COORD_W-1], v} + (COORD_W+1)'(SUB_MASK);
		return t[COORD_W:SUBPIXEL_BITS];
	endfunction

	function automatic logic [PIX_W-1:0] min3(input logic signed [PIX_W-1:0] a,
			input logic signed [PIX_W-1:0] b, input logic signed [PIX_W-1:0] c);
		logic signed [PIX_W-1:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic [PIX_W-1:0] max3(input logic signed [PIX_W-1:0] a,
			input logic signed [PIX_W-1:0] b, input logic signed [PIX_W-1:0] c);
		logic signed [PIX_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	logic signed [COORD_W-1:0] vx [3];
	logic signed [COORD_W-1:0] vy [3];

	s1_t  s1_d;
	s1_t  data_s1;
	logic valid_s1;
	s2_t  s2_d;

	logic signed [PDIFF_W-1:0] dix1, dix2, diy1, diy2;
	logic [SAMP_W-1:0]         sx0, sy0;

	assign vx[0] = vertex_a_x;
	assign vy[0] = vertex_a_y;
	assign vx[1] = vertex_b_x;
	assign vy[1] = vertex_b_y;
	assign vx[2] = vertex_c_x;
	assign vy[2] = vertex_c_y;

	// Stage 1: rounding, edge deltas and fill-rule bias.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			s1_d.vx[i] = vx[i];
			s1_d.vy[i] = vy[i];
			s1_d.ix[i] = ceil_pix(vx[i]);
			s1_d.iy[i] = ceil_pix(vy[i]);
			s1_d.dx[i] = DIFF_W'(vx[i]) - DIFF_W'(vx[(i == 2) ? 0 : i + 1]);
			s1_d.dy[i] = DIFF_W'(vy[i]) - DIFF_W'(vy[(i == 2) ? 0 : i + 1]);
		end
		// Edges that are not top or left edges get their constant lowered by one.
		for (int i = 0; i < 3; i++) begin
			s1_d.bias[i] = !(s1_d.dy[i][DIFF_W-1] ||
				(s1_d.dy[i] == '0 && !s1_d.dx[i][DIFF_W-1] && s1_d.dx[i] != '0));
		end
		s1_d.bx = {block_col, {BLOCK_SHIFT{1'b0}}};
		s1_d.by = {block_row, {BLOCK_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= s1_d;
		end
	end

	// Stage 2: area products, edge constant products and block origin products.
	assign dix1 = PDIFF_W'($signed(data_s1.ix[1])) - PDIFF_W'($signed(data_s1.ix[0]));
	assign dix2 = PDIFF_W'($signed(data_s1.ix[2])) - PDIFF_W'($signed(data_s1.ix[0]));
	assign diy1 = PDIFF_W'($signed(data_s1.iy[1])) - PDIFF_W'($signed(data_s1.iy[0]));
	assign diy2 = PDIFF_W'($signed(data_s1.iy[2])) - PDIFF_W'($signed(data_s1.iy[0]));
	assign sx0  = {1'b0, data_s1.bx, {SUBPIXEL_BITS{1'b0}}};
	assign sy0  = {1'b0, data_s1.by, {SUBPIXEL_BITS{1'b0}}};

	always_comb begin
		s2_d.area_a = AREA_W'(diy2) * AREA_W'(dix1);
		s2_d.area_b = AREA_W'(dix2) * AREA_W'(diy1);
		for (int i = 0; i < 3; i++) begin
			s2_d.cy[i] = PROD_W'($signed(data_s1.dy[i])) * PROD_W'($signed(data_s1.vx[i]));
			s2_d.cx[i] = PROD_W'($signed(data_s1.dx[i])) * PROD_W'($signed(data_s1.vy[i]));
			s2_d.qy[i] = PROD_W'($signed(data_s1.dx[i])) * PROD_W'($signed(sy0));
			s2_d.qx[i] = PROD_W'($signed(data_s1.dy[i])) * PROD_W'($signed(sx0));
		end
		s2_d.min_x = min3(data_s1.ix[0], data_s1.ix[1], data_s1.ix[2]);
		s2_d.max_x = max3(data_s1.ix[0], data_s1.ix[1], data_s1.ix[2]);
		s2_d.min_y = min3(data_s1.iy[0], data_s1.iy[1], data_s1.iy[2]);
		s2_d.max_y = max3(data_s1.iy[0], data_s1.iy[1], data_s1.iy[2]);
		s2_d.dx    = data_s1.dx;
		s2_d.dy    = data_s1.dy;
		s2_d.bias  = data_s1.bias;
		s2_d.bx    = data_s1.bx;
		s2_d.by    = data_s1.by;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= s2_d;
		end
	end

endmodule

### rtl/thc_edge.sv
// Edge stage: triangle status, clamped traversal test, edge constants and step tables.
// Depends on thc_pkg.
module thc_edge import thc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_s2,
	input  s2_t              data_s2,
	input  logic [SCR_W-1:0] screen_width,
	input  logic [SCR_W-1:0] screen_height,
	output logic             valid_s3,
	output s3_t              data_s3
);

	logic signed [BOX_W-1:0] mnx, mxx, mny, mxy, w_s, h_s;
	logic signed [BOX_W-1:0] mnx_c, mxx_c, mny_c, mxy_c, mnx_al, mny_al, bx_s, by_s;
	logic                    zero_area, off_screen;
	s3_t                     s3_d;

	assign mnx  = BOX_W'($signed(data_s2.min_x));
	assign mxx  = BOX_W'($signed(data_s2.max_x));
	assign mny  = BOX_W'($signed(data_s2.min_y));
	assign mxy  = BOX_W'($signed(data_s2.max_y));
	assign w_s  = BOX_W'(screen_width);
	assign h_s  = BOX_W'(screen_height);
	assign bx_s = BOX_W'(data_s2.bx);
	assign by_s = BOX_W'(data_s2.by);

	assign zero_area  = data_s2.area_a == data_s2.area_b;
	assign off_screen = mxy < 0 || mny >= h_s || mxx < 0 || mnx >= w_s;

	// Clamp the box to the screen; the maxima may end up at -1 for an empty screen.
	assign mnx_c  = (mnx < 0) ? '0 : mnx;
	assign mny_c  = (mny < 0) ? '0 : mny;
	assign mxx_c  = (mxx >= w_s) ? w_s - BOX_W'(1) : mxx;
	assign mxy_c  = (mxy >= h_s) ? h_s - BOX_W'(1) : mxy;
	assign mnx_al = {mnx_c[BOX_W-1:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};
	assign mny_al = {mny_c[BOX_W-1:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}};

	always_comb begin
		if (zero_area) begin
			s3_d.status = TRI_ZERO_AREA;
		end else if (off_screen) begin
			s3_d.status = TRI_OFF_SCREEN;
		end else begin
			s3_d.status = TRI_DRAWN;
		end
		s3_d.visited = bx_s >= mnx_al && bx_s < mxx_c && by_s >= mny_al && by_s < mxy_c;
		for (int i = 0; i < 3; i++) begin
			s3_d.c_part[i] = EDGE_W'($signed(data_s2.cy[i])) -
				EDGE_W'($signed(data_s2.cx[i])) - EDGE_W'(data_s2.bias[i]);
			s3_d.s_part[i] = EDGE_W'($signed(data_s2.qy[i])) -
				EDGE_W'($signed(data_s2.qx[i]));
			for (int r = 0; r < BLOCK_SIZE; r++) begin
				s3_d.rstep[i][r] = STEP_W'($signed(data_s2.dx[i]) * r);
				s3_d.cstep[i][r] = STEP_W'($signed(data_s2.dy[i]) * r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= s3_d;
		end
	end

endmodule

### rtl/thc_pixel.sv
// Pixel stages: per-row edge values, then the 64 pixel tests, corner class and result.
// Depends on thc_pkg.
module thc_pixel import thc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s3,
	input  s3_t  data_s3,
	output logic valid_s5,
	output res_t res_s5
);

	typedef struct packed {
		tri_status_t                            status;
		logic                                   visited;
		logic [2:0][BLOCK_SIZE-1:0][EDGE_W-1:0] row_e;
		logic [2:0][BLOCK_SIZE-1:0][STEP_W-1:0] col_off;
	} s4_t;

	s4_t  s4_d;
	s4_t  data_s4;
	logic valid_s4;

	logic [EDGE_W-1:0] pix_e [3][BLOCK_SIZE][BLOCK_SIZE];
	logic              px_in [3][BLOCK_SIZE][BLOCK_SIZE];
	logic [MASK_W-1:0] mask_d;
	logic              any_reject, all_full;
	res_t              res_d;

	// Stage 4: edge value at the first pixel of each row.
	always_comb begin
		s4_d.status  = data_s3.status;
		s4_d.visited = data_s3.visited;
		s4_d.col_off = data_s3.cstep;
		for (int i = 0; i < 3; i++) begin
			for (int r = 0; r < BLOCK_SIZE; r++) begin
				s4_d.row_e[i][r] = data_s3.c_part[i] + data_s3.s_part[i] +
					(EDGE_W'($signed(data_s3.rstep[i][r])) <<< SUBPIXEL_BITS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= s4_d;
		end
	end

	// Stage 5: a pixel is inside an edge when the edge value there is negative.
	for (genvar i = 0; i < 3; i++) begin : g_edge
		for (genvar r = 0; r < BLOCK_SIZE; r++) begin : g_row
			for (genvar k = 0; k < BLOCK_SIZE; k++) begin : g_col
				assign pix_e[i][r][k] = data_s4.row_e[i][r] -
					(EDGE_W'($signed(data_s4.col_off[i][k])) <<< SUBPIXEL_BITS);
				assign px_in[i][r][k] = pix_e[i][r][k][EDGE_W-1];
			end
		end
	end

	always_comb begin
		any_reject = 1'b0;
		all_full   = 1'b1;
		for (int i = 0; i < 3; i++) begin
			any_reject = any_reject | !(px_in[i][0][0] | px_in[i][0][BLOCK_SIZE-1] |
				px_in[i][BLOCK_SIZE-1][0] | px_in[i][BLOCK_SIZE-1][BLOCK_SIZE-1]);
			all_full = all_full & px_in[i][0][0] & px_in[i][0][BLOCK_SIZE-1] &
				px_in[i][BLOCK_SIZE-1][0] & px_in[i][BLOCK_SIZE-1][BLOCK_SIZE-1];
		end
		mask_d = '0;
		for (int r = 0; r < BLOCK_SIZE; r++) begin
			for (int k = 0; k < BLOCK_SIZE; k++) begin
				mask_d[r*MASK_STRIDE+k] = px_in[0][r][k] & px_in[1][r][k] & px_in[2][r][k];
			end
		end
	end

	// Triangles that are not drawn report nothing but their status.
	always_comb begin
		res_d               = '0;
		res_d.status        = data_s4.status;
		res_d.corner_class  = CLASS_REJECT;
		if (data_s4.status == TRI_DRAWN) begin
			res_d.visited = data_s4.visited;
			if (!any_reject) begin
				res_d.corner_class  = all_full ? CLASS_FULL : CLASS_PARTIAL;
				res_d.coverage_mask = mask_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_d;
		end
	end

endmodule

### test/tb_tile_halfspace_coverage_core.sv
// Self-checking testbench for tile_halfspace_coverage_core: directed and random triangle
// and block queries under several screen sizes, with random bursts and output stalls.
// Depends on thc_pkg and the RTL of the block; a scoreboard class predicts every result.
module tb_tile_halfspace_coverage_core;
	import thc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 210;
	localparam int NUM_PHASES = 9;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	typedef struct {
		logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y;
		logic [COL_W-1:0]          col, row;
	} block_query_t;

	typedef struct {
		logic [MASK_W-1:0] mask;
		corner_class_t     cls;
		logic              visited;
		tri_status_t       status;
	} coverage_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_MOSTLY,
		READY_RARELY,
		READY_PERIODIC
	} stall_mode_t;

	class coverage_board;
		logic [SCR_W-1:0] width_px;
		logic [SCR_W-1:0] height_px;
		coverage_t        awaited[$];
		int               errors;
		int               results_seen;

		function new();
			width_px = SCREEN_WIDTH_RST;
			height_px = SCREEN_HEIGHT_RST;
			errors = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
		endtask

		// Round 12.4 up to a whole pixel; the arithmetic shift floors negatives.
		static function longint ceil_pixel(longint v);
			return (v + SUB_MASK) >>> SUBPIXEL_BITS;
		endfunction

		static function bit edge_passes(longint c, longint dx, longint dy, longint sx,
				longint sy);
			return (c + dx * sy - dy * sx) < 0;
		endfunction

		function coverage_t predict(block_query_t q);
			longint    vx[3], vy[3], px[3], py[3], ex[3], ey[3], ec[3];
			longint    area, lo_x, hi_x, lo_y, hi_y, org_x, org_y, w, h;
			longint    sx0, sx1, sy0, sy1, sx, sy, sub_one;
			logic [3:0] hits[3];
			bit        any_empty, all_full, covered;
			int        n;
			coverage_t r;

			r.mask = '0;
			r.cls = CLASS_REJECT;
			r.visited = 1'b0;
			r.status = TRI_DRAWN;
			sub_one = longint'(1) << SUBPIXEL_BITS;
			vx[0] = q.a_x; vy[0] = q.a_y;
			vx[1] = q.b_x; vy[1] = q.b_y;
			vx[2] = q.c_x; vy[2] = q.c_y;
			for (int i = 0; i < 3; i++) begin
				px[i] = ceil_pixel(vx[i]);
				py[i] = ceil_pixel(vy[i]);
			end

			area = (py[2] - py[0]) * (px[1] - px[0]) - (px[2] - px[0]) * (py[1] - py[0]);
			if (area == 0) begin
				r.status = TRI_ZERO_AREA;
				return r;
			end

			lo_x = px[0]; hi_x = px[0]; lo_y = py[0]; hi_y = py[0];
			for (int i = 1; i < 3; i++) begin
				if (px[i] < lo_x) lo_x = px[i];
				if (px[i] > hi_x) hi_x = px[i];
				if (py[i] < lo_y) lo_y = py[i];
				if (py[i] > hi_y) hi_y = py[i];
			end
			w = width_px;
			h = height_px;
			if (hi_y < 0 || lo_y >= h || hi_x < 0 || lo_x >= w) begin
				r.status = TRI_OFF_SCREEN;
				return r;
			end

			if (lo_y < 0) lo_y = 0;
			if (hi_y >= h) hi_y = h - 1;
			if (lo_x < 0) lo_x = 0;
			if (hi_x >= w) hi_x = w - 1;
			lo_x -= lo_x % BLOCK_SIZE;
			lo_y -= lo_y % BLOCK_SIZE;

			org_x = q.col * BLOCK_SIZE;
			org_y = q.row * BLOCK_SIZE;
			r.visited = org_x >= lo_x && org_x < hi_x && org_y >= lo_y && org_y < hi_y;

			// Edge e runs from vertex e to the next one; the fill rule lowers the
			// constant of every edge that is neither rising nor a flat top.
			for (int e = 0; e < 3; e++) begin
				n = (e + 1) % 3;
				ex[e] = vx[e] - vx[n];
				ey[e] = vy[e] - vy[n];
				ec[e] = ey[e] * vx[e] - ex[e] * vy[e];
				if (!(ey[e] < 0 || (ey[e] == 0 && ex[e] > 0)))
					ec[e] = ec[e] - 1;
			end

			sx0 = org_x * sub_one;
			sx1 = (org_x + BLOCK_SIZE - 1) * sub_one;
			sy0 = org_y * sub_one;
			sy1 = (org_y + BLOCK_SIZE - 1) * sub_one;
			any_empty = 1'b0;
			all_full = 1'b1;
			for (int e = 0; e < 3; e++) begin
				hits[e] = {edge_passes(ec[e], ex[e], ey[e], sx1, sy1),
					edge_passes(ec[e], ex[e], ey[e], sx1, sy0),
					edge_passes(ec[e], ex[e], ey[e], sx0, sy1),
					edge_passes(ec[e], ex[e], ey[e], sx0, sy0)};
				if (hits[e] == 4'h0) any_empty = 1'b1;
				if (hits[e] != 4'hF) all_full = 1'b0;
			end
			if (any_empty)
				return r;

			r.cls = all_full ? CLASS_FULL : CLASS_PARTIAL;
			for (int rr = 0; rr < BLOCK_SIZE; rr++) begin
				for (int k = 0; k < BLOCK_SIZE; k++) begin
					sx = (org_x + k) * sub_one;
					sy = (org_y + rr) * sub_one;
					covered = 1'b1;
					for (int e = 0; e < 3; e++)
						if (!edge_passes(ec[e], ex[e], ey[e], sx, sy)) covered = 1'b0;
					if (covered) r.mask[rr * MASK_STRIDE + k] = 1'b1;
				end
			end
			return r;
		endfunction

		function void note_query(block_query_t q);
			awaited.insert(awaited.size(), predict(q));
		endfunction

		task check_result(logic [MASK_W-1:0] mask, logic [1:0] cls, logic visited,
				logic [1:0] status);
			coverage_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				report("result transaction with no query pending");
				return;
			end
			want = awaited.pop_front();
			if (mask !== want.mask)
				report($sformatf("coverage_mask %h, expected %h", mask, want.mask));
			if (cls !== want.cls)
				report($sformatf("corner_class %0d, expected %s", cls, want.cls.name()));
			if (visited !== want.visited)
				report($sformatf("block_visited %b, expected %b", visited, want.visited));
			if (status !== want.status)
				report($sformatf("triangle_status %0d, expected %s", status,
					want.status.name()));
		endtask
	endclass

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [COORD_W-1:0] vertex_a_x = '0;
	logic signed [COORD_W-1:0] vertex_a_y = '0;
	logic signed [COORD_W-1:0] vertex_b_x = '0;
	logic signed [COORD_W-1:0] vertex_b_y = '0;
	logic signed [COORD_W-1:0] vertex_c_x = '0;
	logic signed [COORD_W-1:0] vertex_c_y = '0;
	logic [COL_W-1:0]          block_col = '0;
	logic [COL_W-1:0]          block_row = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [MASK_W-1:0]         coverage_mask;
	logic [1:0]                corner_class;
	logic                      block_visited;
	logic [1:0]                triangle_status;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [SCR_W-1:0]          cfg_data = '0;

	coverage_board sb;
	stall_mode_t   stall_mode = READY_ALWAYS;
	int unsigned   stall_left = 0;
	int            idle_cycles = 0;

	tile_halfspace_coverage_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vertex_a_x(vertex_a_x),
		.vertex_a_y(vertex_a_y),
		.vertex_b_x(vertex_b_x),
		.vertex_b_y(vertex_b_y),
		.vertex_c_x(vertex_c_x),
		.vertex_c_y(vertex_c_y),
		.block_col(block_col),
		.block_row(block_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.coverage_mask(coverage_mask),
		.corner_class(corner_class),
		.block_visited(block_visited),
		.triangle_status(triangle_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The receiver switches among stall patterns, holding each for a random length.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(coverage_mask, corner_class, block_visited, triangle_status);
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
			READY_RARELY: out_ready <= ($urandom_range(0, 9) < 3);
			default: out_ready <= (stall_left[1:0] == 2'b00);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [COORD_W-1:0] clip16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] jitter(int center, int span);
		return clip16(longint'(center) + longint'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic block_query_t make_query(int ax, int ay, int bx, int by, int cx,
			int cy, int col, int row);
		block_query_t q;
		q.a_x = COORD_W'(ax); q.a_y = COORD_W'(ay);
		q.b_x = COORD_W'(bx); q.b_y = COORD_W'(by);
		q.c_x = COORD_W'(cx); q.c_y = COORD_W'(cy);
		q.col = COL_W'(col); q.row = COL_W'(row);
		return q;
	endfunction

	task send_query(block_query_t q);
		in_valid <= 1'b1;
		vertex_a_x <= q.a_x;
		vertex_a_y <= q.a_y;
		vertex_b_x <= q.b_x;
		vertex_b_y <= q.b_y;
		vertex_c_x <= q.c_x;
		vertex_c_y <= q.c_y;
		block_col <= q.col;
		block_row <= q.row;
		do @(posedge clk); while (!in_ready);
		sb.note_query(q);
	endtask

	// Writes both screen registers back to back, optionally followed by an ignored index.
	task set_screen(int w, int h, bit poke_spare);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= SCR_W'(w);
		do @(posedge clk); while (!cfg_ready);
		sb.width_px = SCR_W'(w);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= SCR_W'(h);
		do @(posedge clk); while (!cfg_ready);
		sb.height_px = SCR_W'(h);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= SCR_W'($urandom);
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly triangles built around the queried block so that partial and full blocks
	// are common; the rest are raw random fields and degenerate shapes.
	task run_random(int count);
		block_query_t q;
		int sent, burst, gap, kind, span, lim_c, lim_r, cx0, cy0;
		sent = 0;
		while (sent < count) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (sent > 0 && gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				kind = $urandom_range(0, 99);
				lim_c = (sb.width_px >> BLOCK_SHIFT) + 1;
				lim_r = (sb.height_px >> BLOCK_SHIFT) + 1;
				if (lim_c > 255) lim_c = 255;
				if (lim_r > 255) lim_r = 255;
				q.col = COL_W'($urandom_range(0, lim_c));
				q.row = COL_W'($urandom_range(0, lim_r));
				if (kind < 12) begin
					q.a_x = COORD_W'($urandom); q.a_y = COORD_W'($urandom);
					q.b_x = COORD_W'($urandom); q.b_y = COORD_W'($urandom);
					q.c_x = COORD_W'($urandom); q.c_y = COORD_W'($urandom);
					q.col = COL_W'($urandom); q.row = COL_W'($urandom);
				end else begin
					span = (kind < 75) ? (16 << $urandom_range(0, 7))
						: (16 << $urandom_range(8, 11));
					cx0 = q.col * 128 + $urandom_range(0, 127);
					cy0 = q.row * 128 + $urandom_range(0, 127);
					q.a_x = jitter(cx0, span); q.a_y = jitter(cy0, span);
					q.b_x = jitter(cx0, span); q.b_y = jitter(cy0, span);
					q.c_x = jitter(cx0, span); q.c_y = jitter(cy0, span);
					if (kind >= 90 && kind < 95) begin
						q.c_x = q.a_x;
						q.c_y = q.a_y;
					end else if (kind >= 95) begin
						q.c_x = clip16(2 * longint'(q.b_x) - q.a_x);
						q.c_y = clip16(2 * longint'(q.b_y) - q.a_y);
					end
				end
				send_query(q);
				sent++;
			end
		end
	endtask

	int phase_w[NUM_PHASES] = '{2048, 1, 0, 4095, 37, 2048, 0, 0, 640};
	int phase_h[NUM_PHASES] = '{2048, 1, 0, 4095, 2048, 9, 0, 0, 480};

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset screen size of 640 by 480.
		send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, -32768, 0, 0));
		send_query(make_query(32767, 32767, -32768, 32767, 32767, -32768, 255, 255));
		send_query(make_query(160, 160, 160, 160, 480, 320, 1, 1));
		send_query(make_query(1, 1, 5, 3, 9, 14, 0, 0));
		send_query(make_query(0, 0, 160, 160, 320, 320, 0, 0));
		send_query(make_query(-320, 0, -160, 160, -480, 320, 0, 0));
		send_query(make_query(10256, 0, 10400, 160, 10300, 320, 80, 0));
		send_query(make_query(0, -320, 160, -160, 320, -480, 0, 0));
		send_query(make_query(0, 7680, 160, 7840, 320, 7700, 0, 60));
		send_query(make_query(0, 0, 2048, 0, 0, 2048, 0, 0));
		send_query(make_query(0, 0, 0, 2048, 2048, 0, 0, 0));
		send_query(make_query(0, 2048, 2048, 2048, 1024, 0, 0, 1));
		send_query(make_query(16, 16, 96, 16, 16, 96, 10, 10));
		send_query(make_query(-160, -160, 480, -160, -160, 480, 0, 0));
		send_query(make_query(10080, 7520, 10300, 7520, 10080, 7700, 79, 59));
		send_query(make_query(3, 5, 1000, 13, 7, 1009, 1, 1));
		send_query(make_query(128, 128, 256, 128, 128, 256, 1, 1));
		send_query(make_query(128, 128, 128, 256, 256, 128, 1, 1));
		settle();

		phase_w[6] = $urandom_range(1, 2048);
		phase_h[6] = $urandom_range(1, 2048);
		phase_w[7] = $urandom_range(1, 2048);
		phase_h[7] = $urandom_range(1, 2048);
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_screen(phase_w[p], phase_h[p], p == 0);
			run_random(PHASE_ITEMS);
			settle();
		end

		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
